// ===== design/ilwa_pkg.sv =====
// ----------------------------------------------------------------------------
// ilwa_pkg
// Shared types, register codes and helpers for the inline run line wrap and
// align block.
// ----------------------------------------------------------------------------
`default_nettype none

package ilwa_pkg;

  localparam int LINE_RUNS_DEF = 32;
  localparam int CNT_MAX_W     = 6;
  localparam int IDX_MAX_W     = 6;

  localparam logic [11:0] CONTENT_WIDTH_RST   = 12'd640;
  localparam logic [9:0]  MIN_LINE_HEIGHT_RST = 10'd16;

  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

  typedef enum logic [2:0] {
    REG_CONTENT_LEFT,
    REG_CONTENT_TOP,
    REG_CONTENT_WIDTH,
    REG_TEXT_ALIGNMENT,
    REG_MIN_LINE_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] content_left;
    logic [15:0] content_top;
    logic [11:0] content_width;
    logic [1:0]  text_alignment;
    logic [9:0]  min_line_height;
  } cfg_t;

  typedef struct packed {
    logic [11:0] run_width;
    logic [9:0]  run_height;
    logic        last_run;
  } item_t;

  typedef struct packed {
    logic [12:0] run_x;
    logic [15:0] run_y;
    logic [15:0] line_number;
    logic        forced_wrap;
    logic        last_result;
    logic [15:0] bottom_y;
  } result_t;

  typedef struct packed {
    logic                 bank;
    logic [CNT_MAX_W-1:0] count;
    logic [17:0]          line_sum;
    logic [15:0]          y;
    logic [15:0]          line;
    logic [9:0]           height;
    logic                 forced;
    logic                 last;
  } line_desc_t;

  typedef struct packed {
    logic                 valid;
    logic                 bank;
    logic [IDX_MAX_W-1:0] idx;
    logic [11:0]          offset;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/ilwa_fifo.sv =====
// ----------------------------------------------------------------------------
// ilwa_fifo
// Two-entry first-in first-out buffer used for line descriptors and results.
// ----------------------------------------------------------------------------
`default_nettype none

module ilwa_fifo #(
  parameter type entry_t = logic
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_valid,
  input  wire entry_t wr_data,
  output logic        full,
  output logic [1:0]  level,
  output entry_t      rd_data,
  output logic        empty,
  input  wire logic   rd_pop
);

  entry_t     slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       do_wr;
  logic       do_rd;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign level   = cnt;
  assign rd_data = slots[rptr];
  assign do_wr   = wr_valid && !full;
  assign do_rd   = rd_pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_wr) wptr <= !wptr;
      if (do_rd) rptr <= !rptr;
      cnt <= cnt + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_data;
  end

endmodule

`default_nettype wire

// ===== design/ilwa_front.sv =====
// ----------------------------------------------------------------------------
// ilwa_front
// Accepts runs, decides line breaks, tracks the cursor and line state, writes
// run offsets into the line store and hands finished lines to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ilwa_front
  import ilwa_pkg::*;
#(
  parameter int LINE_RUNS = LINE_RUNS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      push,
  output logic           full,
  input  wire item_t     item,
  output store_wr_t      store_wr,
  output logic           desc_valid,
  output line_desc_t     desc,
  input  wire logic      desc_full,
  input  wire release_t  rel
);

  localparam int CNT_W = $clog2(LINE_RUNS + 1);

  logic             in_valid;
  item_t            in_item;
  logic [12:0]      cursor;
  logic [17:0]      line_sum;
  logic [9:0]       height;
  logic [15:0]      line_top;
  logic [15:0]      line_idx;
  logic [CNT_W-1:0] count;
  logic             cur;
  logic [1:0]       busy;

  logic             width_wrap;
  logic             store_full;
  logic             do_flush;
  logic             do_append;
  logic [9:0]       height_new;
  logic [13:0]      reach;

  always_comb begin
    reach      = {1'b0, cursor} + 14'(in_item.run_width);
    width_wrap = (cursor != 13'd0) && (reach > 14'(cfg.content_width));
    store_full = (count == CNT_W'(LINE_RUNS));
    do_flush   = in_valid && (width_wrap || store_full);
    do_append  = in_valid && !do_flush && !busy[cur];
    full       = in_valid && !do_append;
    height_new = (in_item.run_height > height) ? in_item.run_height : height;

    store_wr.valid  = do_append;
    store_wr.bank   = cur;
    store_wr.idx    = IDX_MAX_W'(count);
    store_wr.offset = cursor[11:0];

    desc_valid  = do_flush || (do_append && in_item.last_run);
    desc.bank   = cur;
    desc.y      = line_top;
    desc.line   = line_idx;
    if (do_flush) begin
      desc.count    = CNT_MAX_W'(count);
      desc.line_sum = line_sum;
      desc.height   = height;
      desc.forced   = store_full && !width_wrap;
      desc.last     = 1'b0;
    end else begin
      desc.count    = CNT_MAX_W'(count + CNT_W'(1));
      desc.line_sum = line_sum + 18'(in_item.run_width);
      desc.height   = height_new;
      desc.forced   = 1'b0;
      desc.last     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cursor   <= 13'd0;
      line_sum <= 18'd0;
      height   <= MIN_LINE_HEIGHT_RST;
      line_top <= 16'd0;
      line_idx <= 16'd0;
      count    <= '0;
      cur      <= 1'b0;
      busy     <= 2'b00;
    end else begin
      if (push && !full) begin
        in_valid <= 1'b1;
      end else if (do_append) begin
        in_valid <= 1'b0;
      end

      if (desc_valid) cur <= !cur;
      for (int b = 0; b < 2; b++) begin
        if (desc_valid && (cur == 1'(b))) begin
          busy[b] <= 1'b1;
        end else if (rel.valid && (rel.bank == 1'(b))) begin
          busy[b] <= 1'b0;
        end
      end

      if (do_flush) begin
        line_top <= sat16(17'(line_top) + 17'(height));
        line_idx <= (line_idx != 16'hFFFF) ? line_idx + 16'd1 : line_idx;
        cursor   <= 13'd0;
        line_sum <= 18'd0;
        count    <= '0;
        height   <= cfg.min_line_height;
      end else if (do_append) begin
        if (in_item.last_run) begin
          line_top <= cfg.content_top;
          line_idx <= 16'd0;
          cursor   <= 13'd0;
          line_sum <= 18'd0;
          count    <= '0;
          height   <= cfg.min_line_height;
        end else begin
          cursor   <= cursor + 13'(in_item.run_width);
          line_sum <= line_sum + 18'(in_item.run_width);
          count    <= count + CNT_W'(1);
          height   <= height_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) in_item <= item;
  end

  a_desc_space: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> !desc_full)
    else $error("line handed off with descriptor queue full");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    do_flush |=> (count == '0) && (cursor == 13'd0))
    else $error("line state not cleared after break");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    do_append |-> (count < CNT_W'(LINE_RUNS)))
    else $error("line store written past its depth");

endmodule

`default_nettype wire

// ===== design/ilwa_back.sv =====
// ----------------------------------------------------------------------------
// ilwa_back
// Holds the two-bank line store and replays each finished line one run per
// cycle while the output queue has room: aligned x, line y, line number, paragraph bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module ilwa_back
  import ilwa_pkg::*;
#(
  parameter int LINE_RUNS = LINE_RUNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire store_wr_t  store_wr,
  input  wire line_desc_t desc,
  input  wire logic       desc_empty,
  output logic            desc_pop,
  output release_t        rel,
  output result_t         result,
  output logic            empty,
  input  wire logic       pop
);

  localparam int IDX_W = (LINE_RUNS > 1) ? $clog2(LINE_RUNS) : 1;
  localparam int DEPTH = 2 ** (IDX_W + 1);

  typedef struct packed {
    logic [12:0] base;
    logic [15:0] y;
    logic [15:0] line;
    logic        forced;
    logic        last;
    logic [15:0] bottom;
  } meta_t;

  logic [11:0] store [DEPTH];

  logic                 active;
  logic                 bank;
  logic [CNT_MAX_W-1:0] count;
  logic [CNT_MAX_W-1:0] idx;
  meta_t                line_meta;
  logic                 infl;
  meta_t                infl_meta;
  logic [11:0]          rd_offset;

  logic                 load;
  logic [17:0]          cw_ext;
  logic [11:0]          slack;
  logic [11:0]          shift;
  logic                 issue;
  logic                 last_read;
  logic [2:0]           occ;
  logic [1:0]           of_level;
  logic                 of_full;
  result_t              of_wr;

  always_comb begin
    load     = !active && !desc_empty;
    desc_pop = load;
    cw_ext   = 18'(cfg.content_width);
    slack    = (cw_ext > desc.line_sum) ? 12'(cw_ext - desc.line_sum) : 12'd0;
    case (cfg.text_alignment)
      ALIGN_CENTER: shift = slack >> 1;
      ALIGN_RIGHT:  shift = slack;
      default:      shift = 12'd0;
    endcase

    occ       = 3'(of_level) + 3'(infl) - 3'(pop && !empty);
    issue     = active && (occ < 3'd2);
    last_read = (idx == count - CNT_MAX_W'(1));
    rel.valid = issue && last_read;
    rel.bank  = bank;

    of_wr.run_x       = infl_meta.base + 13'(rd_offset);
    of_wr.run_y       = infl_meta.y;
    of_wr.line_number = infl_meta.line;
    of_wr.forced_wrap = infl_meta.forced;
    of_wr.last_result = infl_meta.last;
    of_wr.bottom_y    = infl_meta.bottom;
  end

  always_ff @(posedge clk) begin
    if (store_wr.valid) store[{store_wr.bank, store_wr.idx[IDX_W-1:0]}] <= store_wr.offset;
    if (issue) rd_offset <= store[{bank, idx[IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      infl   <= 1'b0;
      idx    <= '0;
    end else begin
      infl <= issue;
      if (load) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (issue) begin
        idx <= idx + CNT_MAX_W'(1);
        if (last_read) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank             <= desc.bank;
      count            <= desc.count;
      line_meta.base   <= 13'(cfg.content_left) + 13'(shift);
      line_meta.y      <= desc.y;
      line_meta.line   <= desc.line;
      line_meta.forced <= desc.forced;
      line_meta.last   <= desc.last;
      line_meta.bottom <= desc.last ? sat16(17'(desc.y) + 17'(desc.height)) : 16'd0;
    end
    if (issue) begin
      infl_meta.base   <= line_meta.base;
      infl_meta.y      <= line_meta.y;
      infl_meta.line   <= line_meta.line;
      infl_meta.forced <= line_meta.forced;
      infl_meta.last   <= line_meta.last && last_read;
      infl_meta.bottom <= (line_meta.last && last_read) ? line_meta.bottom : 16'd0;
    end
  end

  ilwa_fifo #(
    .entry_t (result_t)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (infl),
    .wr_data  (of_wr),
    .full     (of_full),
    .level    (of_level),
    .rd_data  (result),
    .empty    (empty),
    .rd_pop   (pop)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    infl |-> (!of_full || pop))
    else $error("result dropped on full output queue");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (idx < count))
    else $error("line store read past line length");

  a_bottom_only_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.last_result) |-> (result.bottom_y == 16'd0))
    else $error("bottom y set on a run that does not end the paragraph");

endmodule

`default_nettype wire

// ===== design/inline_run_line_wrap_align_top.sv =====
// a handed-off line passes the descriptor queue, load, store read and output queue
// the front holds a line-breaking run while it flushes the line, or while its bank is busy
// replay: 1 result/cycle from the registered store read port, when the output queue has room
// each line starts with a descriptor load; two line banks let fill and replay overlap
// reset (rst, synchronous, active high) empties all queues and restores register defaults
// ----------------------------------------------------------------------------
// inline_run_line_wrap_align_top
// Greedy line breaker with left, center or right alignment of inline runs.
// ----------------------------------------------------------------------------
`default_nettype none

module inline_run_line_wrap_align_top
  import ilwa_pkg::*;
#(
  parameter int LINE_RUNS = LINE_RUNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire item_t       item,
  output logic             empty,
  input  wire logic        pop,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  logic       wr_en;
  store_wr_t  store_wr;
  logic       desc_valid;
  line_desc_t desc_in;
  line_desc_t desc_out;
  logic       desc_full;
  logic       desc_empty;
  logic       desc_pop;
  logic [1:0] desc_level;
  release_t   rel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.content_left    <= 12'd0;
      cfg.content_top     <= 16'd0;
      cfg.content_width   <= CONTENT_WIDTH_RST;
      cfg.text_alignment  <= ALIGN_LEFT;
      cfg.min_line_height <= MIN_LINE_HEIGHT_RST;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_CONTENT_LEFT:    cfg.content_left    <= pwdata[11:0];
        REG_CONTENT_TOP:     cfg.content_top     <= pwdata[15:0];
        REG_CONTENT_WIDTH:   cfg.content_width   <= pwdata[11:0];
        REG_TEXT_ALIGNMENT:  cfg.text_alignment  <= pwdata[1:0];
        REG_MIN_LINE_HEIGHT: cfg.min_line_height <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CONTENT_LEFT:    prdata = 32'(cfg.content_left);
      REG_CONTENT_TOP:     prdata = 32'(cfg.content_top);
      REG_CONTENT_WIDTH:   prdata = 32'(cfg.content_width);
      REG_TEXT_ALIGNMENT:  prdata = 32'(cfg.text_alignment);
      REG_MIN_LINE_HEIGHT: prdata = 32'(cfg.min_line_height);
      default:             prdata = 32'd0;
    endcase
  end

  ilwa_front #(
    .LINE_RUNS (LINE_RUNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .item       (item),
    .store_wr   (store_wr),
    .desc_valid (desc_valid),
    .desc       (desc_in),
    .desc_full  (desc_full),
    .rel        (rel)
  );

  ilwa_fifo #(
    .entry_t (line_desc_t)
  ) u_desc_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (desc_valid),
    .wr_data  (desc_in),
    .full     (desc_full),
    .level    (desc_level),
    .rd_data  (desc_out),
    .empty    (desc_empty),
    .rd_pop   (desc_pop)
  );

  ilwa_back #(
    .LINE_RUNS (LINE_RUNS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .store_wr   (store_wr),
    .desc       (desc_out),
    .desc_empty (desc_empty),
    .desc_pop   (desc_pop),
    .rel        (rel),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

  a_desc_level: assert property (@(posedge clk) disable iff (rst)
    (desc_level == 2'd2) |-> !desc_valid)
    else $error("descriptor queue overrun");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the inline run line wrap and align block. Runs are
// pushed through the input queue while a scoreboard places them on lines with
// its own greedy wrap and alignment logic and compares every popped result.
// ----------------------------------------------------------------------------

module tb;
  import ilwa_pkg::*;

  localparam logic [1:0] ALIGN_UNUSED = 2'd3;
  localparam logic [1:0] ALIGN_CODES [4] = '{ALIGN_LEFT, ALIGN_CENTER, ALIGN_RIGHT,
                                             ALIGN_UNUSED};
  localparam int SEND_IDLE_PCT [4] = '{0, 58, 0, 34};
  localparam int POP_STALL_PCT [4] = '{0, 0, 58, 34};
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES = 600;

  class layout_scoreboard;
    logic [11:0] left_x;
    logic [15:0] top_y;
    logic [11:0] box_width;
    logic [1:0]  align;
    logic [9:0]  min_height;

    logic [12:0] cursor;
    logic [15:0] line_y;
    logic [9:0]  line_height;
    logic [15:0] line_idx;
    logic [17:0] width_sum;
    logic [11:0] run_offsets [LINE_RUNS_DEF];
    int          run_count;
    bit          cut_by_store;

    result_t placed_q [$];
    int errors;
    int n_runs;
    int n_checked;
    int n_lines;
    int n_cut;
    int n_paragraphs;

    function new();
      left_x     = '0;
      top_y      = '0;
      box_width  = CONTENT_WIDTH_RST;
      align      = ALIGN_LEFT;
      min_height = MIN_LINE_HEIGHT_RST;
      line_y     = top_y;
      line_idx   = '0;
      begin_line();
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_CONTENT_LEFT:    left_x = v[11:0];
        REG_CONTENT_TOP:     top_y = v[15:0];
        REG_CONTENT_WIDTH:   box_width = v[11:0];
        REG_TEXT_ALIGNMENT:  align = v[1:0];
        REG_MIN_LINE_HEIGHT: min_height = v[9:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] add_sat16(logic [15:0] a, logic [9:0] b);
      logic [16:0] s;
      s = {1'b0, a} + 17'(b);
      return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function void begin_line();
      cursor       = '0;
      width_sum    = '0;
      run_count    = 0;
      cut_by_store = 1'b0;
      line_height  = min_height;
    endfunction

    function void emit_line(bit closing);
      logic [17:0] slack;
      logic [12:0] shift;
      result_t r;
      slack = (18'(box_width) > width_sum) ? 18'(box_width) - width_sum : '0;
      case (align)
        ALIGN_CENTER: shift = slack[12:0] >> 1;
        ALIGN_RIGHT:  shift = slack[12:0];
        default:      shift = '0;
      endcase
      for (int i = 0; i < run_count; i++) begin
        r.run_x       = 13'(left_x) + 13'(run_offsets[i]) + shift;
        r.run_y       = line_y;
        r.line_number = line_idx;
        r.forced_wrap = cut_by_store;
        r.last_result = closing && (i == run_count - 1);
        r.bottom_y    = r.last_result ? add_sat16(line_y, line_height) : '0;
        placed_q.push_back(r);
      end
      n_lines++;
      if (cut_by_store) n_cut++;
    endfunction

    function void note_run(item_t it);
      bit wrap;
      bit store_full;
      n_runs++;
      wrap = (cursor != 0) && (int'(cursor) + int'(it.run_width) > int'(box_width));
      store_full = run_count >= LINE_RUNS_DEF;
      if (wrap || store_full) begin
        cut_by_store = store_full && !wrap;
        emit_line(1'b0);
        line_y = add_sat16(line_y, line_height);
        if (line_idx != 16'hFFFF) line_idx++;
        begin_line();
      end
      run_offsets[run_count] = cursor[11:0];
      run_count++;
      cursor    = cursor + 13'(it.run_width);
      width_sum = width_sum + 18'(it.run_width);
      if (it.run_height > line_height) line_height = it.run_height;
      if (it.last_run) begin
        emit_line(1'b1);
        n_paragraphs++;
        line_y   = top_y;
        line_idx = '0;
        begin_line();
      end
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_placement(result_t got);
      result_t want;
      if (placed_q.size() == 0) begin
        $error("result with nothing expected: run_x %0d run_y %0d", got.run_x, got.run_y);
        errors++;
        return;
      end
      want = placed_q.pop_front();
      n_checked++;
      compare("run_x", 16'(want.run_x), 16'(got.run_x));
      compare("run_y", want.run_y, got.run_y);
      compare("line_number", want.line_number, got.line_number);
      compare("forced_wrap", 16'(want.forced_wrap), 16'(got.forced_wrap));
      compare("last_result", 16'(want.last_result), 16'(got.last_result));
      compare("bottom_y", want.bottom_y, got.bottom_y);
    endfunction

    function int waiting();
      return placed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  item_t       item = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  layout_scoreboard sb;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  bit hold_req = 1'b0;

  inline_run_line_wrap_align_top uut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // result side: check each transfer, then pick pop for the next cycle
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_placement(result);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
      end
    end
  end

  function automatic item_t mk_run(int w, int h, bit fin);
    item_t it;
    it.run_width  = w[11:0];
    it.run_height = h[9:0];
    it.last_run   = fin;
    return it;
  endfunction

  task automatic send_item(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    sb.note_run(it);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(r, v);
  endtask

  task automatic apply_layout(logic [11:0] cl, logic [15:0] ct, logic [11:0] cw,
                              logic [1:0] al, logic [9:0] mh);
    write_reg(REG_CONTENT_LEFT, {20'd0, cl});
    write_reg(REG_CONTENT_TOP, {16'd0, ct});
    write_reg(REG_CONTENT_WIDTH, {20'd0, cw});
    write_reg(REG_TEXT_ALIGNMENT, {30'd0, al});
    write_reg(REG_MIN_LINE_HEIGHT, {22'd0, mh});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_paragraph(int n, int wmax, bit tall);
    item_t it;
    for (int k = 0; k < n; k++) begin
      it.run_width  = 12'($urandom_range(0, wmax));
      it.run_height = tall ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 40));
      it.last_run   = (k == n - 1);
      send_item(it);
    end
  endtask

  initial begin
    logic [11:0] cl;
    logic [15:0] ct;
    logic [11:0] cw;
    logic [9:0]  mh;
    int budget;
    int sent;
    int n;
    int wmax;
    int sel;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset layout: zero width runs, overwide run, exact fit, width wraps
    send_item(mk_run(0, 0, 0));
    send_item(mk_run(4095, 1023, 0));
    send_item(mk_run(0, 0, 0));
    send_item(mk_run(10, 5, 0));
    send_item(mk_run(600, 20, 0));
    send_item(mk_run(30, 1, 0));
    send_item(mk_run(1, 0, 1));
    wait_idle();
    // center, widest box, saturating bottom y on the second paragraph
    apply_layout(12'd4095, 16'd65535, 12'd4095, ALIGN_CENTER, 10'd1023);
    send_item(mk_run(100, 1, 0));
    send_item(mk_run(4095, 0, 0));
    send_item(mk_run(7, 1023, 1));
    send_item(mk_run(5, 3, 0));
    send_item(mk_run(4000, 2, 1));
    wait_idle();
    apply_layout(12'd17, 16'd300, 12'd0, ALIGN_RIGHT, 10'd1);
    send_item(mk_run(0, 0, 0));
    send_item(mk_run(3, 1, 0));
    send_item(mk_run(2, 2, 1));
    wait_idle();
    apply_layout(12'd1, 16'd0, 12'd100, ALIGN_UNUSED, 10'd16);
    send_item(mk_run(40, 7, 0));
    send_item(mk_run(70, 9, 1));
    send_item(mk_run(50, 0, 1));
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        cl = '0; ct = '0; cw = 12'd4095; mh = 10'd1;
      end else if (p == 1) begin
        cl = 12'd4095; ct = 16'd65535; cw = '0; mh = 10'd1023;
      end else begin
        cl = 12'($urandom_range(0, 4095));
        ct = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(65000, 65535))
                                         : 16'($urandom_range(0, 2000));
        cw = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                         : 12'($urandom_range(100, 900));
        mh = $urandom_range(0, 1) ? 10'($urandom_range(1, 40))
                                  : 10'($urandom_range(1, 1023));
      end
      apply_layout(cl, ct, cw, ALIGN_CODES[p % 4], mh);
      send_idle_pct = SEND_IDLE_PCT[p % 4];
      pop_stall_pct = POP_STALL_PCT[p % 4];
      budget = (p == 4) ? 45 : 25;
      sent = 0;
      if (p == 4) hold_req = 1'b1;
      if (p % 2 == 0) begin
        send_paragraph(34, 1, 1'b0);
        sent += 34;
      end
      while (sent < budget) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          n = $urandom_range(1, 12);
          wmax = cw / 4 + 1;
        end else if (sel < 8) begin
          n = $urandom_range(1, 8);
          wmax = 4095;
        end else begin
          n = $urandom_range(33, 40);
          wmax = (sel == 8) ? 2 : 0;
        end
        send_paragraph(n, wmax, $urandom_range(0, 1));
        sent += n;
      end
      wait_idle();
    end

    $display("tb: %0d runs in %0d paragraphs, %0d results checked on %0d lines",
             sb.n_runs, sb.n_paragraphs, sb.n_checked, sb.n_lines);
    $display("tb: %0d lines cut at a full store; all alignments, stalls and a long hold",
             sb.n_cut);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ilwa_pkg.sv
design/ilwa_fifo.sv
design/ilwa_front.sv
design/ilwa_back.sv
design/inline_run_line_wrap_align_top.sv
tb/tb.sv
